FILE: rtl/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

    // Operation codes carried in the low bits of the input tdata.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Result tdata: found, status, entry_count, padded to two bytes.
    localparam int COUNT_OUT_W = 7;
    localparam int M_TDATA_W   = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;         // capture a new item, rewind the walk
        logic       adv;          // step to the next entry, keep the old entry
        logic       wr_key;       // write the new key at the current index
        logic       wr_carry;     // write the displaced entry at the current index
        logic       shift_on;     // from now on every step moves entries up
        logic       set_found;    // capture the equality of the current entry
        logic       set_status;   // capture status_val
        logic [1:0] status_val;
        logic       inc_count;
        logic       clear_count;
        logic       out_load;     // move the finished result to the output register
    } skt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_op;        // operation of the item on the input channel
        logic [1:0] op;           // operation of the item in progress
        logic       at_end;       // walk index has reached the stored count
        logic       ge;           // current entry is not less than the key
        logic       eq;           // current entry equals the key
        logic       full;         // store holds its capacity
        logic       shifting;
        logic       reject_dup;
        logic       out_free;     // output register can take a result this cycle
    } skt_stat_t;

endpackage

FILE: rtl/skt_ctrl.sv
`timescale 1ns / 1ps

module skt_ctrl
    import skt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  skt_stat_t stat,
    output skt_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (stat.in_op)
                        OP_INSERT, OP_LOOKUP: begin
                            state_next = S_WALK;
                        end
                        OP_CLEAR: begin
                            cmd.clear_count = 1'b1;
                            state_next      = S_OUT;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (stat.shifting) begin
                    // Carry the displaced entry one place up.
                    cmd.wr_carry = 1'b1;
                    if (stat.at_end) begin
                        cmd.inc_count = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        cmd.adv = 1'b1;
                    end
                end else if (stat.at_end) begin
                    // Key is larger than every stored entry.
                    if (stat.op == OP_INSERT) begin
                        if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_FULL;
                        end else begin
                            cmd.wr_key    = 1'b1;
                            cmd.inc_count = 1'b1;
                        end
                    end
                    state_next = S_OUT;
                end else if (stat.ge) begin
                    cmd.set_found = 1'b1;
                    if (stat.op != OP_INSERT) begin
                        state_next = S_OUT;
                    end else if (stat.reject_dup && stat.eq) begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_DUP;
                        state_next     = S_OUT;
                    end else if (stat.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_FULL;
                        state_next     = S_OUT;
                    end else begin
                        cmd.wr_key   = 1'b1;
                        cmd.shift_on = 1'b1;
                        cmd.adv      = 1'b1;
                    end
                end else begin
                    cmd.adv = 1'b1;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Only one of the two write sources drives the memory in a cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_key && cmd.wr_carry))
        else $error("skt_ctrl: key and carry written together");

    // A new item is taken only when the controller is back at rest.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> s_tready)
        else $error("skt_ctrl: not ready after result handoff");

endmodule

FILE: rtl/skt_dp.sv
`timescale 1ns / 1ps

module skt_dp
    import skt_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    parameter int S_TDATA_W = ((2 + KEY_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  skt_cmd_t             cmd,
    output skt_stat_t            stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [KEY_WIDTH-1:0] entry_mem [CAPACITY];

    logic [KEY_WIDTH-1:0]   key_reg, carry_reg, rdata_reg;
    logic [1:0]             op_reg, status_reg;
    logic [CW-1:0]          idx_reg, count_reg;
    logic                   shifting_reg, found_reg, reject_reg;
    logic                   m_valid_reg, m_found_reg;
    logic [1:0]             m_status_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;

    logic [CW-1:0]          idx_inc;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [KEY_WIDTH-1:0]   mem_wdata;

    assign idx_inc   = idx_reg + 1'b1;
    // At rest the read port points at entry 0, so the walk starts with data in hand.
    assign rd_addr   = cmd.adv ? idx_inc[AW-1:0] : '0;
    assign mem_we    = cmd.wr_key || cmd.wr_carry;
    assign mem_wdata = cmd.wr_key ? key_reg : carry_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[idx_reg[AW-1:0]] <= mem_wdata;
        end
        rdata_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg      <= s_tdata[KEY_WIDTH+1:2];
            op_reg       <= s_tdata[1:0];
            idx_reg      <= '0;
            shifting_reg <= 1'b0;
            found_reg    <= 1'b0;
            status_reg   <= ST_DONE;
        end else begin
            if (cmd.adv) begin
                idx_reg   <= idx_inc;
                carry_reg <= rdata_reg;
            end
            if (cmd.shift_on) begin
                shifting_reg <= 1'b1;
            end
            if (cmd.set_found) begin
                found_reg <= stat.eq;
            end
            if (cmd.set_status) begin
                status_reg <= cmd.status_val;
            end
        end
        if (cmd.out_load) begin
            m_found_reg  <= found_reg;
            m_status_reg <= status_reg;
            m_count_reg  <= COUNT_OUT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            reject_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_count) begin
                count_reg <= '0;
            end else if (cmd.inc_count) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                reject_reg <= cfg_wr_data;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.in_op      = s_tdata[1:0];
        stat.op         = op_reg;
        stat.at_end     = (idx_reg == count_reg);
        stat.ge         = ($signed(rdata_reg) >= $signed(key_reg));
        stat.eq         = (rdata_reg == key_reg);
        stat.full       = (count_reg == CAP_C);
        stat.shifting   = shifting_reg;
        stat.reject_dup = reject_reg;
        stat.out_free   = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_OUT_W - 3){1'b0}},
                       m_count_reg, m_status_reg, m_found_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("skt_dp: count above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.inc_count |-> !stat.full)
        else $error("skt_dp: insert into a full store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (idx_reg <= count_reg) && !stat.full)
        else $error("skt_dp: write outside the stored range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("skt_dp: result not presented after load");

endmodule

FILE: rtl/sorted_key_table.sv
// An insert or lookup walks the entries from index 0 before its result is ready;
// clear and no-op go straight to the result. The block takes one item at a time:
// a new item is accepted only once the last result has moved to the output
// register. Reset (aresetn low, synchronous) empties the store, clears the
// duplicate-reject register and drops any waiting result.
`timescale 1ns / 1ps

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,

    // Input channel.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // From bit 0: operation (2), key (KEY_WIDTH, signed), zero padding.
    input  logic [((2 + KEY_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,

    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0: found (1), status (2), entry_count (7), zero padding.
    output logic [M_TDATA_W-1:0] m_tdata,

    // Duplicate-reject register, to be written only while the block is idle; the block does not enforce this.
    input  logic cfg_wr_en,
    input  logic cfg_wr_data
);

    // The store is a single memory of CAPACITY keys kept in ascending order.
    // Entries at or above the stored count are never used, so the memory needs
    // no clearing pass. An insert or lookup walks the entries from index 0, one
    // per cycle. A lookup stops at the first entry not less than the key. An
    // insert writes the key there and then ripples each displaced entry one
    // place up in the same forward walk, so each move does one read and one
    // write at neighboring addresses.

    localparam int S_TDATA_W = ((2 + KEY_WIDTH + 7) / 8) * 8;

    skt_cmd_t  cmd;
    skt_stat_t stat;

    // The controller sequences each item: accept, walk (insert or lookup),
    // then hand the result to the output register once it is free.
    skt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the key memory, the count, the walk registers and
    // the output register, which lets a finished result wait on the result
    // channel while the next item is accepted.
    skt_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .S_TDATA_W (S_TDATA_W)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
